### design/assert_macros.svh
// assertion macros shared by the line breaker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MRLB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MRLB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define MRLB_ASSERT(label, clk, rst_n, prop, msg)
`define MRLB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### design/mrlb_pkg.sv
// types and constants of the minimum raggedness line breaker
`default_nettype none
package mrlb_pkg;

    localparam int MAX_WORDS = 64;
    localparam int CNT_W = $clog2(MAX_WORDS + 1);
    localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

    localparam int LEN_W = 8;
    localparam int IDX_W = 7;
    localparam int COST_W = 30;
    localparam int PEN_W = 24;
    localparam int SP_W = 10;
    localparam int TDATA_W = 64;
    localparam int FIELDS_W = 3 * IDX_W + LEN_W + COST_W;

    localparam logic [LEN_W-1:0] LINE_WIDTH_RESET = 8'd75;
    localparam logic [COST_W-1:0] COST_MAX = 30'h3FFF_FFFF;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [COST_W-1:0] cost_t;
    typedef logic [PEN_W-1:0] pen_t;
    typedef logic signed [SP_W-1:0] sp_t;

    typedef struct packed {
        cnt_t  lines;
        cost_t cost;
    } cost_word_t;

    typedef struct packed {
        cnt_t start;
        len_t spare;
    } bp_word_t;

    typedef struct packed {
        logic  clear;
        logic  take;
        cost_t cost_prev;
        cnt_t  lines_prev;
        pen_t  pen;
        cnt_t  where;
        len_t  spare;
    } cand_req_t;

    typedef struct packed {
        cost_t cost;
        cnt_t  lines_prev;
        cnt_t  where;
        len_t  spare;
    } cand_res_t;

endpackage
`default_nettype wire

### design/mrlb_mult.sv
// shared 16 by 8 multiplier with registered product, used for squaring and cubing
`default_nettype none
module mrlb_mult (
    input  wire logic                       clk,
    input  wire logic [15:0]                a,
    input  wire logic [7:0]                 b,
    output logic      [mrlb_pkg::PEN_W-1:0] prod
);
    import mrlb_pkg::*;

    pen_t prod_reg;
    pen_t prod_next;

    always_comb
    begin
        prod_next = pen_t'({8'b0, a} * {16'b0, b});
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

### design/mrlb_cand.sv
// candidate evaluation: saturating cost add, compare and best candidate registers
`default_nettype none
module mrlb_cand (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mrlb_pkg::cand_req_t req,
    output mrlb_pkg::cand_res_t      res
);
    import mrlb_pkg::*;

    logic      have_reg;
    logic      have_next;
    cand_res_t best_reg;
    cand_res_t best_next;
    logic [COST_W:0] sum;
    cost_t     cost_sat;

    always_comb
    begin
        sum = {1'b0, req.cost_prev} + {{(COST_W + 1 - PEN_W){1'b0}}, req.pen};
        cost_sat = (sum > {1'b0, COST_MAX}) ? COST_MAX : sum[COST_W-1:0];
        have_next = have_reg;
        best_next = best_reg;
        if (req.clear)
        begin
            have_next = 1'b0;
        end
        else if (req.take)
        begin
            // strict compare keeps the latest line start on a tie
            if (!have_reg || (cost_sat < best_reg.cost))
            begin
                have_next = 1'b1;
                best_next.cost = cost_sat;
                best_next.lines_prev = req.lines_prev;
                best_next.where = req.where;
                best_next.spare = req.spare;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
    end

    assign res = best_reg;

endmodule
`default_nettype wire

### design/min_raggedness_line_breaker.sv
// line breaker top: sequencer, word, cost and back pointer stores, output register
//
// input stream: one word per transaction, tdata[7:0] = word length, tlast marks
// the last word of the paragraph. cfg_wen/cfg_wdata write the line width
// (reset 75); the user writes it only while the block is idle (not enforced).
// output stream: one transaction per line, last line first. tdata holds, from
// bit 0 up, line number, first word, last word, spare spaces and total cost;
// tuser is the error flag and tlast marks the final transaction of a run.
// an over-wide word or more than 64 words gives a single error transaction.
// each word walks back over the candidate line starts that still fit; each
// candidate passes the fetch, cube and compare states on the shared
// multiplier and compare unit, then a write state stores the best, with tready
// low until the sequencer is idle again. a word that is not costed skips the
// walk. after the last word, the result walk passes the read and head states,
// then emits one line per cycle unless stalled, each a back pointer store read.
// the last transaction sits in the output register while the next paragraph
// is taken; a stalled receiver holds the walk at its current line.
// reset empties the paragraph, restores the line width and drops tvalid.
`default_nettype none
`include "assert_macros.svh"
module min_raggedness_line_breaker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wen,
    input  wire logic [mrlb_pkg::LEN_W-1:0]   cfg_wdata,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [mrlb_pkg::LEN_W-1:0]   s_axis_tdata,   // word_length
    input  wire logic                         s_axis_tlast,   // final_word
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // line_number, first_word, end_word, spare_spaces, total_cost, zero fill
    output logic      [mrlb_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic                              m_axis_tuser,   // error
    output logic                              m_axis_tlast    // last
);
    import mrlb_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_FETCH = 9'b000000010,
        S_CUBE  = 9'b000000100,
        S_CMP   = 9'b000001000,
        S_WRITE = 9'b000010000,
        S_ERR   = 9'b000100000,
        S_RD    = 9'b001000000,
        S_HEAD  = 9'b010000000,
        S_EMIT  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    len_t   line_width_reg, line_width_next;
    cnt_t   wc_reg, wc_next;
    logic   ovf_reg, ovf_next;
    logic   out_valid_reg, out_valid_next;

    logic   fin_reg, fin_next;
    cnt_t   j_reg, j_next;
    cnt_t   i_reg, i_next;
    sp_t    sp_reg, sp_next;
    cnt_t   x_reg, x_next;
    cnt_t   lnum_reg, lnum_next;
    cost_t  total_reg, total_next;
    logic [TDATA_W-1:0] out_data_reg, out_data_next;
    logic   out_user_reg, out_user_next;
    logic   out_last_reg, out_last_next;

    len_t       len_mem [MAX_WORDS];
    cost_word_t cost_mem [MAX_WORDS];
    bp_word_t   bp_mem [MAX_WORDS];
    len_t       len_rd_reg;
    cost_word_t cost_rd_reg;
    bp_word_t   bp_rd_reg;

    logic       len_we, cost_we, bp_we;
    logic       len_re, cost_re, bp_re;
    addr_t      len_waddr, res_waddr, rd_addr;
    cost_word_t cost_wdata;
    bp_word_t   bp_wdata;

    logic [15:0] mul_a;
    len_t        mul_b;
    pen_t        prod;
    cand_req_t   cand_req;
    cand_res_t   cand_res;

    logic   slot_free;
    len_t   len_in;
    sp_t    sp_step;
    cnt_t   wc_inc;
    cnt_t   i_m2;
    cnt_t   start_m2;

    mrlb_mult u_mult (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    mrlb_cand u_cand (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cand_req),
        .res   (cand_res)
    );

    always_comb
    begin
        state_next = state_reg;
        line_width_next = cfg_wen ? cfg_wdata : line_width_reg;
        wc_next = wc_reg;
        ovf_next = ovf_reg;
        fin_next = fin_reg;
        j_next = j_reg;
        i_next = i_reg;
        sp_next = sp_reg;
        x_next = x_reg;
        lnum_next = lnum_reg;
        total_next = total_reg;
        out_data_next = out_data_reg;
        out_user_next = out_user_reg;
        out_last_next = out_last_reg;

        slot_free = !out_valid_reg || m_axis_tready;
        out_valid_next = out_valid_reg && !m_axis_tready;

        len_in = s_axis_tdata;
        wc_inc = wc_reg + cnt_t'(1);
        i_m2 = i_reg - cnt_t'(2);
        start_m2 = bp_rd_reg.start - cnt_t'(2);
        sp_step = sp_reg - sp_t'({2'b00, len_rd_reg}) - sp_t'(1);

        len_we = 1'b0;
        cost_we = 1'b0;
        bp_we = 1'b0;
        len_re = 1'b0;
        cost_re = 1'b0;
        bp_re = 1'b0;
        len_waddr = addr_t'(wc_reg);
        res_waddr = addr_t'(j_reg - cnt_t'(1));
        rd_addr = addr_t'(i_m2);
        cost_wdata.lines = cand_res.lines_prev + cnt_t'(1);
        cost_wdata.cost = cand_res.cost;
        bp_wdata.start = cand_res.where;
        bp_wdata.spare = cand_res.spare;

        mul_a = {8'b0, sp_reg[7:0]};
        mul_b = sp_reg[7:0];

        cand_req.clear = 1'b0;
        cand_req.take = 1'b0;
        cand_req.cost_prev = (i_reg == cnt_t'(1)) ? '0 : cost_rd_reg.cost;
        cand_req.lines_prev = (i_reg == cnt_t'(1)) ? '0 : cost_rd_reg.lines;
        cand_req.pen = fin_reg ? '0 : prod;
        cand_req.where = i_reg;
        cand_req.spare = sp_reg[7:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    fin_next = s_axis_tlast;
                    if (wc_reg >= cnt_t'(MAX_WORDS))
                    begin
                        ovf_next = 1'b1;
                        state_next = s_axis_tlast ? S_ERR : S_IDLE;
                    end
                    else
                    begin
                        len_we = 1'b1;
                        wc_next = wc_inc;
                        j_next = wc_inc;
                        i_next = wc_inc;
                        sp_next = sp_t'({2'b00, line_width_reg}) - sp_t'({2'b00, len_in});
                        if (len_in > line_width_reg)
                        begin
                            ovf_next = 1'b1;
                            state_next = s_axis_tlast ? S_ERR : S_IDLE;
                        end
                        else if (ovf_reg)
                        begin
                            state_next = s_axis_tlast ? S_ERR : S_IDLE;
                        end
                        else
                        begin
                            cand_req.clear = 1'b1;
                            state_next = S_FETCH;
                        end
                    end
                end
            end
            S_FETCH:
            begin
                len_re = 1'b1;
                cost_re = 1'b1;
                state_next = S_CUBE;
            end
            S_CUBE:
            begin
                mul_a = prod[15:0];
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cand_req.take = 1'b1;
                i_next = i_reg - cnt_t'(1);
                sp_next = sp_step;
                if ((i_reg == cnt_t'(1)) || sp_step[SP_W-1])
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_WRITE:
            begin
                cost_we = 1'b1;
                bp_we = 1'b1;
                state_next = fin_reg ? S_RD : S_IDLE;
            end
            S_ERR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = '0;
                    out_user_next = 1'b1;
                    out_last_next = 1'b1;
                    wc_next = '0;
                    ovf_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_RD:
            begin
                rd_addr = addr_t'(wc_reg - cnt_t'(1));
                cost_re = 1'b1;
                bp_re = 1'b1;
                x_next = wc_reg;
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                total_next = cost_rd_reg.cost;
                lnum_next = cost_rd_reg.lines;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                rd_addr = addr_t'(start_m2);
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = {{(TDATA_W - FIELDS_W){1'b0}}, total_reg,
                                     bp_rd_reg.spare, IDX_W'(x_reg),
                                     IDX_W'(bp_rd_reg.start), IDX_W'(lnum_reg)};
                    out_user_next = 1'b0;
                    out_last_next = (bp_rd_reg.start == cnt_t'(1));
                    if (bp_rd_reg.start == cnt_t'(1))
                    begin
                        wc_next = '0;
                        ovf_next = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        bp_re = 1'b1;
                        x_next = bp_rd_reg.start - cnt_t'(1);
                        lnum_next = lnum_reg - cnt_t'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            line_width_reg <= LINE_WIDTH_RESET;
            wc_reg <= '0;
            ovf_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            line_width_reg <= line_width_next;
            wc_reg <= wc_next;
            ovf_reg <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_reg <= fin_next;
        j_reg <= j_next;
        i_reg <= i_next;
        sp_reg <= sp_next;
        x_reg <= x_next;
        lnum_reg <= lnum_next;
        total_reg <= total_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    // word length store
    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_waddr] <= len_in;
        end
        if (len_re)
        begin
            len_rd_reg <= len_mem[rd_addr];
        end
    end

    // best cost and line count store
    always_ff @(posedge clk)
    begin
        if (cost_we)
        begin
            cost_mem[res_waddr] <= cost_wdata;
        end
        if (cost_re)
        begin
            cost_rd_reg <= cost_mem[rd_addr];
        end
    end

    // back pointer and spare store
    always_ff @(posedge clk)
    begin
        if (bp_we)
        begin
            bp_mem[res_waddr] <= bp_wdata;
        end
        if (bp_re)
        begin
            bp_rd_reg <= bp_mem[rd_addr];
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = out_user_reg;
    assign m_axis_tlast = out_last_reg;

    `MRLB_ASSERT_IMPL(a_err_last, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "error transaction without tlast")
    `MRLB_ASSERT(a_wc_bound, clk, rst_n, wc_reg <= cnt_t'(MAX_WORDS), "word count beyond store depth")
    `MRLB_ASSERT_IMPL(a_i_range, clk, rst_n, state_reg == S_FETCH || state_reg == S_CUBE || state_reg == S_CMP, i_reg != '0 && i_reg <= j_reg, "candidate start out of range")
    `MRLB_ASSERT_IMPL(a_sp_fit, clk, rst_n, state_reg == S_FETCH, !sp_reg[SP_W-1], "candidate line with negative spare")

endmodule
`default_nettype wire
